FILE: hdl/http_chunked_body_decoder_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the chunked body decoder
// Shared same-cycle and next-cycle implication forms, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef HTTP_CHUNKED_BODY_DECODER_UNIT_MACROS_SVH
`define HTTP_CHUNKED_BODY_DECODER_UNIT_MACROS_SVH

// same-cycle implication
`define HCBD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hcbd assertion failed");

// next-cycle implication
`define HCBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hcbd assertion failed");

`endif

FILE: hdl/hcbd_pkg.sv
// ----------------------------------------------------------------------------
// hcbd_pkg
// Types, codes and byte helpers for the chunked body decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

  localparam logic [7:0]  ByteCr       = 8'd13;
  localparam logic [7:0]  ByteLf       = 8'd10;
  localparam logic [31:0] MaxBodyReset = 32'd1048576;

  typedef enum logic [1:0] {
    ST_BUSY = 2'd0,
    ST_DONE = 2'd1,
    ST_BAD  = 2'd2,
    ST_BIG  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    PH_SIZE_FIRST    = 4'd0,
    PH_SIZE          = 4'd1,
    PH_SIZE_LF       = 4'd2,
    PH_DATA          = 4'd3,
    PH_DATA_CR       = 4'd4,
    PH_DATA_LF       = 4'd5,
    PH_TRAILER_START = 4'd6,
    PH_TRAILER       = 4'd7,
    PH_TRAILER_LF    = 4'd8,
    PH_FINAL_LF      = 4'd9,
    PH_HOLD          = 4'd10
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_message;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic [1:0]  status;
    logic [31:0] body_length;
  } out_item_t;

  // {is_hex, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= "0" && c <= "9") begin
      r = {1'b1, 4'(c - "0")};
    end else if (c >= "a" && c <= "f") begin
      r = {1'b1, 4'(c - "a" + 8'd10)};
    end else if (c >= "A" && c <= "F") begin
      r = {1'b1, 4'(c - "A" + 8'd10)};
    end
    return r;
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") ||
           (c >= "A" && c <= "Z");
  endfunction

endpackage

FILE: hdl/http_chunked_body_decoder_unit.sv
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_unit
// HTTP/1.1 chunked transfer decoder, one body byte per beat.
// ----------------------------------------------------------------------------
// Takes one raw body byte per clock and returns one result beat per byte
// through an input register, then a result register. The decoder state
// (phase, chunk size, byte count, body total) updates once per byte, so a new
// byte can enter every cycle; throughput is bounded only by out_stall. The
// result carries the payload byte when the input was chunk data, the message
// status and the total of fully accepted chunks. start_message on a beat
// clears the decoder before that byte is parsed. Write max_body_size over
// the cfg port only while the decoder is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`include "http_chunked_body_decoder_unit_macros.svh"

module http_chunked_body_decoder_unit #(
  parameter int LENGTH_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  hcbd_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output hcbd_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [31:0]          cfg_data
);
  import hcbd_pkg::*;

  localparam int CmpW = 64;

  logic                   s1_valid_r;
  in_item_t               s1_data_r;
  logic                   s2_ready;
  logic                   advance;
  logic                   out_valid_r;
  out_item_t              out_data_r;
  logic [31:0]            max_r;

  phase_t                 phase_r, phase_nxt, ph_cur;
  status_t                status_r, status_nxt, st_cur;
  logic [LENGTH_BITS-1:0] len_r, len_nxt, len_cur;
  logic [LENGTH_BITS-1:0] cnt_r, cnt_nxt, cnt_cur, cnt_inc;
  logic [31:0]            tot_r, tot_nxt, tot_cur;

  logic [7:0]             c;
  logic [4:0]             hex;
  logic                   hex_ok, is_cr, is_lf, len_ovf, last_byte, too_big, len_zero;
  logic [CmpW-1:0]        len_ext, room_ext, sum_ext;
  logic                   pay_v;

  assign cfg_ready = 1'b1;
  assign s2_ready  = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !s2_ready;
  assign advance   = s1_valid_r && s2_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= MaxBodyReset;
    end else if (cfg_valid && cfg_ready) begin
      max_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_data_r <= in_data;
    end
  end

  // state seen by this byte, after an optional message restart
  always_comb begin
    c = s1_data_r.data_byte;
    if (s1_data_r.start_message) begin
      ph_cur  = PH_SIZE_FIRST;
      st_cur  = ST_BUSY;
      len_cur = '0;
      cnt_cur = '0;
      tot_cur = '0;
    end else begin
      ph_cur  = phase_r;
      st_cur  = status_r;
      len_cur = len_r;
      cnt_cur = cnt_r;
      tot_cur = tot_r;
    end
  end

  assign hex       = hex_decode(c);
  assign hex_ok    = hex[4];
  assign is_cr     = (c == ByteCr);
  assign is_lf     = (c == ByteLf);
  assign len_ovf   = |len_cur[LENGTH_BITS-1:LENGTH_BITS-4];
  assign len_zero  = (len_cur == '0);
  assign cnt_inc   = cnt_cur + LENGTH_BITS'(1);
  assign last_byte = (cnt_inc == len_cur);
  assign len_ext   = CmpW'(len_cur);
  assign room_ext  = CmpW'(max_r) - CmpW'(tot_cur);
  assign too_big   = (len_ext > room_ext);
  assign sum_ext   = CmpW'(tot_cur) + len_ext;

  // next phase and status
  always_comb begin
    phase_nxt  = ph_cur;
    status_nxt = st_cur;
    unique case (ph_cur)
      PH_SIZE_FIRST: begin
        if (!hex_ok) begin
          phase_nxt = PH_HOLD; status_nxt = ST_BAD;
        end else begin
          phase_nxt = PH_SIZE;
        end
      end
      PH_SIZE: begin
        if (is_cr) begin
          phase_nxt = PH_SIZE_LF;
        end else if (!hex_ok || len_ovf) begin
          phase_nxt = PH_HOLD; status_nxt = ST_BAD;
        end
      end
      PH_SIZE_LF: begin
        if (!is_lf) begin
          phase_nxt = PH_HOLD; status_nxt = ST_BAD;
        end else begin
          phase_nxt = len_zero ? PH_TRAILER_START : PH_DATA;
        end
      end
      PH_DATA: begin
        if (last_byte) begin
          phase_nxt = PH_DATA_CR;
        end
      end
      PH_DATA_CR: begin
        if (!is_cr) begin
          phase_nxt = PH_HOLD; status_nxt = ST_BAD;
        end else begin
          phase_nxt = PH_DATA_LF;
        end
      end
      PH_DATA_LF: begin
        if (!is_lf) begin
          phase_nxt = PH_HOLD; status_nxt = ST_BAD;
        end else if (too_big) begin
          phase_nxt = PH_HOLD; status_nxt = ST_BIG;
        end else begin
          phase_nxt = PH_SIZE_FIRST;
        end
      end
      PH_TRAILER_START: begin
        if (is_cr) begin
          phase_nxt = PH_FINAL_LF;
        end else if (is_alnum(c)) begin
          phase_nxt = PH_TRAILER;
        end else begin
          phase_nxt = PH_HOLD; status_nxt = ST_BAD;
        end
      end
      PH_TRAILER: begin
        if (is_cr) begin
          phase_nxt = PH_TRAILER_LF;
        end
      end
      PH_TRAILER_LF: begin
        if (!is_lf) begin
          phase_nxt = PH_HOLD; status_nxt = ST_BAD;
        end else begin
          phase_nxt = PH_TRAILER_START;
        end
      end
      PH_FINAL_LF: begin
        phase_nxt  = PH_HOLD;
        status_nxt = is_lf ? ST_DONE : ST_BAD;
      end
      PH_HOLD: begin
        phase_nxt = PH_HOLD;
      end
      default: begin
        phase_nxt = ph_cur;
      end
    endcase
  end

  // datapath and payload
  always_comb begin
    len_nxt = len_cur;
    cnt_nxt = cnt_cur;
    tot_nxt = tot_cur;
    pay_v   = 1'b0;
    unique case (ph_cur)
      PH_SIZE_FIRST: begin
        if (hex_ok) begin
          len_nxt = LENGTH_BITS'(hex[3:0]);
          cnt_nxt = '0;
        end
      end
      PH_SIZE: begin
        if (!is_cr && hex_ok && !len_ovf) begin
          len_nxt = {len_cur[LENGTH_BITS-5:0], hex[3:0]};
        end
      end
      PH_DATA: begin
        pay_v   = 1'b1;
        cnt_nxt = cnt_inc;
      end
      PH_DATA_LF: begin
        if (is_lf && !too_big) begin
          tot_nxt = sum_ext[31:0];
          len_nxt = '0;
          cnt_nxt = '0;
        end
      end
      default: begin
        pay_v = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SIZE_FIRST;
      status_r <= ST_BUSY;
      len_r    <= '0;
      cnt_r    <= '0;
      tot_r    <= '0;
    end else if (advance) begin
      phase_r  <= phase_nxt;
      status_r <= status_nxt;
      len_r    <= len_nxt;
      cnt_r    <= cnt_nxt;
      tot_r    <= tot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r.payload_byte  <= pay_v ? c : 8'd0;
      out_data_r.payload_valid <= pay_v;
      out_data_r.status        <= status_nxt;
      out_data_r.body_length   <= tot_nxt;
    end
  end

  `HCBD_ASSERT_IMPL(a_payload_only_busy, clk, rst_n,
    out_valid_r && out_data_r.payload_valid, out_data_r.status == ST_BUSY)
  `HCBD_ASSERT_IMPL(a_hold_matches_status, clk, rst_n,
    1'b1, (phase_r == PH_HOLD) == (status_r != ST_BUSY))
  `HCBD_ASSERT_IMPL(a_count_below_size, clk, rst_n,
    phase_r == PH_DATA, cnt_r < len_r)
  `HCBD_ASSERT_NEXT(a_advance_fills_out, clk, rst_n,
    advance, out_valid_r)

endmodule
